FILE: hw/rtl/fasta_fastq_record_parser_unit_macros.svh
// Assertion macros for the FASTA/FASTQ record parser.
// Expect clk and rst in the scope of use; empty when SYNTH is defined.
`ifndef FASTA_FASTQ_RECORD_PARSER_UNIT_MACROS_SVH
`define FASTA_FASTQ_RECORD_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
`define FFRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffrp: same-cycle check failed");
`define FFRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffrp: next-cycle check failed");
`else
`define FFRP_ASSERT_NOW(label, ante, cons)
`define FFRP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/ffrp_pkg.sv
// Shared types, codes and constants for the FASTA/FASTQ record parser.
// No dependencies.
package ffrp_pkg;

  localparam int ADDR_W    = 16;
  localparam int LEN_W     = 16;
  localparam logic [ADDR_W-1:0] BUF_LIMIT = 16'hFFFF;  // min(buffer size, 65535)

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_NAME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_SEQUENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_QUALITY  = 2'd2;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [1:0] FLD_NAME     = 2'd0;
  localparam logic [1:0] FLD_SEQUENCE = 2'd1;
  localparam logic [1:0] FLD_QUALITY  = 2'd2;

  typedef enum logic [2:0] {
    K_WRITE      = 3'd0,
    K_DONE       = 3'd1,
    K_STREAM_END = 3'd2,
    K_BAD_HEADER = 3'd3,
    K_TRUNCATED  = 3'd4,
    K_OVERFLOW   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    PH_WAIT          = 4'd0,
    PH_NAME_FIRST    = 4'd1,
    PH_NAME          = 4'd2,
    PH_FA_LSTART     = 4'd3,
    PH_FA_LINE       = 4'd4,
    PH_FQ_SEQ        = 4'd5,
    PH_FQ_PLUS       = 4'd6,
    PH_FQ_QUAL_FIRST = 4'd7,
    PH_FQ_QUAL       = 4'd8,
    PH_HALT          = 4'd9
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [1:0]        field;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_byte;
    logic              is_fastq;
    logic [LEN_W-1:0]  name_len;
    logic [LEN_W-1:0]  seq_len;
    logic [LEN_W-1:0]  qual_len;
  } res_t;

  // Results of one input byte: r0 first, r1 only when two is set.
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } push_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

FILE: hw/rtl/ffrp_if.sv
// Valid/ready channel interfaces for the record parser's byte input and result output.
// Depends on nothing.
interface ffrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface ffrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  field;
  logic [15:0] wr_addr;
  logic [7:0]  wr_byte;
  logic        is_fastq;
  logic [15:0] name_len;
  logic [15:0] seq_len;
  logic [15:0] qual_len;
  logic        last;

  modport source (output valid, kind, field, wr_addr, wr_byte, is_fastq, name_len,
                  seq_len, qual_len, last, input ready);
  modport sink   (input valid, kind, field, wr_addr, wr_byte, is_fastq, name_len,
                  seq_len, qual_len, last, output ready);
endinterface

FILE: hw/rtl/fasta_fastq_record_parser_unit.sv
// FASTA/FASTQ record parser. Takes one text byte (or an end-of-stream mark) per
// transaction and turns it into zero, one or two results: buffer writes of name,
// sequence and quality bytes, record-done lengths, stream end, or an error that
// halts parsing until reset. A byte is taken every clock; the parse state updates
// in the cycle it is accepted and its results go into a two-group result queue.
// Results leave at one per clock while the receiver is ready, so throughput is one
// byte per cycle except when a byte yields two results (record end with stream end
// or a bad header); input ready drops only while the queue is full.
// Writes sit at 0..65534 of the record buffer; there is no start-up clearing pass.
// Depends on ffrp_pkg, ffrp_if, ffrp_core, ffrp_queue and the macros header.
`include "fasta_fastq_record_parser_unit_macros.svh"

module fasta_fastq_record_parser_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ffrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  ffrp_in_if.sink                        in_ch,
  ffrp_out_if.source                     out_ch
);

  ffrp_pkg::push_t push;
  logic            full;

  ffrp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .in_ch     (in_ch),
    .push      (push)
  );

  ffrp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .out_ch (out_ch)
  );

  logic out_acc, halt_kind;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign halt_kind = (out_ch.kind == ffrp_pkg::K_BAD_HEADER) ||
                     (out_ch.kind == ffrp_pkg::K_TRUNCATED) ||
                     (out_ch.kind == ffrp_pkg::K_OVERFLOW);

  `FFRP_ASSERT_NOW(a_fasta_no_qual, out_ch.valid && out_ch.kind == ffrp_pkg::K_DONE && !out_ch.is_fastq, out_ch.qual_len == 16'd0)
  `FFRP_ASSERT_NOW(a_halt_is_last, out_ch.valid && halt_kind, out_ch.last)
  `FFRP_ASSERT_NOW(a_addr_only_on_write, out_ch.valid && out_ch.kind != ffrp_pkg::K_WRITE, out_ch.wr_addr == 16'd0)
  `FFRP_ASSERT_NEXT(a_silent_after_halt, out_acc && halt_kind, !out_ch.valid)

endmodule

FILE: hw/rtl/ffrp_core.sv
// Parse state machine: per-byte phase and pointer update, result generation.
// Depends on ffrp_pkg and ffrp_in_if.
module ffrp_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ffrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           full,
  ffrp_in_if.sink                        in_ch,
  output ffrp_pkg::push_t                push
);

  ffrp_pkg::phase_t phase, phase_next;
  logic [15:0] wp, wp_next;
  logic [15:0] mk, mk_next;
  logic [15:0] fs, fs_next;
  logic [15:0] snl, snl_next;
  logic [15:0] ssl, ssl_next;
  logic        fq, fq_next;
  logic        drop_name, drop_sequence, drop_quality;

  logic        in_acc;
  logic [7:0]  b;
  logic        eos;

  // actions of the current byte
  logic        st_store, st_ovf, st_trunc, st_done, st_end, st_bad;
  logic [1:0]  st_fld;
  logic [15:0] done_nl, done_sl, done_ql;

  ffrp_pkg::res_t res [2];
  logic [1:0]     cnt;

  assign in_ch.ready = !full;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign eos         = in_ch.end_of_stream;

  // next state
  always_comb begin
    phase_next = phase;
    wp_next    = wp;
    mk_next    = mk;
    fs_next    = fs;
    snl_next   = snl;
    ssl_next   = ssl;
    fq_next    = fq;
    st_store   = 1'b0;
    st_fld     = ffrp_pkg::FLD_NAME;
    st_ovf     = 1'b0;
    st_trunc   = 1'b0;
    st_done    = 1'b0;
    st_end     = 1'b0;
    st_bad     = 1'b0;
    done_nl    = '0;
    done_sl    = '0;
    done_ql    = drop_quality ? 16'd0 : 16'(mk - fs);

    unique case (phase)
      ffrp_pkg::PH_WAIT: begin
        if (eos) st_end = 1'b1;
      end
      ffrp_pkg::PH_NAME_FIRST, ffrp_pkg::PH_NAME: begin
        if (eos) begin
          if (phase == ffrp_pkg::PH_NAME_FIRST) begin
            st_end = 1'b1;
          end else if (fq) begin
            st_trunc = 1'b1;
          end else begin
            st_done  = 1'b1;
            st_end   = 1'b1;
            done_nl  = drop_name ? 16'd0 : mk;
            done_sl  = '0;
            done_ql  = '0;
          end
        end else if (b == ffrp_pkg::CH_LF) begin
          // close the name: trailing blanks trimmed
          snl_next   = drop_name ? 16'd0 : mk;
          wp_next    = drop_name ? 16'd0 : mk;
          fs_next    = wp_next;
          mk_next    = wp_next;
          phase_next = fq ? ffrp_pkg::PH_FQ_SEQ : ffrp_pkg::PH_FA_LSTART;
        end else begin
          phase_next = ffrp_pkg::PH_NAME;
          st_store   = !drop_name;
          st_fld     = ffrp_pkg::FLD_NAME;
        end
      end
      ffrp_pkg::PH_FA_LSTART: begin
        if (eos) begin
          st_done = 1'b1;
          st_end  = 1'b1;
          done_nl = snl;
          done_sl = 16'(wp - fs);
          done_ql = '0;
        end else if (ffrp_pkg::is_ws(b)) begin
          phase_next = phase;
        end else if (b >= ffrp_pkg::CH_UPPER_A && b <= ffrp_pkg::CH_LOWER_Z) begin
          phase_next = ffrp_pkg::PH_FA_LINE;
          st_store   = 1'b1;
          st_fld     = ffrp_pkg::FLD_SEQUENCE;
        end else begin
          // this byte opens the next record
          st_done = 1'b1;
          done_nl = snl;
          done_sl = 16'(wp - fs);
          done_ql = '0;
        end
      end
      ffrp_pkg::PH_FA_LINE: begin
        if (eos) begin
          st_done = 1'b1;
          st_end  = 1'b1;
          done_nl = snl;
          done_sl = 16'(mk - fs);
          done_ql = '0;
        end else if (b == ffrp_pkg::CH_LF) begin
          wp_next    = mk;
          phase_next = ffrp_pkg::PH_FA_LSTART;
        end else begin
          st_store = 1'b1;
          st_fld   = ffrp_pkg::FLD_SEQUENCE;
        end
      end
      ffrp_pkg::PH_FQ_SEQ: begin
        if (eos) begin
          st_trunc = 1'b1;
        end else if (b == ffrp_pkg::CH_LF) begin
          wp_next    = drop_sequence ? fs : mk;
          ssl_next   = drop_sequence ? 16'd0 : 16'(mk - fs);
          fs_next    = wp_next;
          mk_next    = wp_next;
          phase_next = ffrp_pkg::PH_FQ_PLUS;
        end else begin
          st_store = !drop_sequence;
          st_fld   = ffrp_pkg::FLD_SEQUENCE;
        end
      end
      ffrp_pkg::PH_FQ_PLUS: begin
        if (eos) begin
          st_trunc = 1'b1;
        end else if (b == ffrp_pkg::CH_LF) begin
          phase_next = ffrp_pkg::PH_FQ_QUAL_FIRST;
        end
      end
      ffrp_pkg::PH_FQ_QUAL_FIRST, ffrp_pkg::PH_FQ_QUAL: begin
        if (eos) begin
          if (phase == ffrp_pkg::PH_FQ_QUAL_FIRST) begin
            st_trunc = 1'b1;
          end else begin
            st_done = 1'b1;
            st_end  = 1'b1;
            done_nl = snl;
            done_sl = ssl;
          end
        end else if (b == ffrp_pkg::CH_LF) begin
          st_done = 1'b1;
          done_nl = snl;
          done_sl = ssl;
        end else begin
          phase_next = ffrp_pkg::PH_FQ_QUAL;
          st_store   = !drop_quality;
          st_fld     = ffrp_pkg::FLD_QUALITY;
        end
      end
      ffrp_pkg::PH_HALT: begin
        phase_next = phase;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (st_store) begin
      if (wp >= ffrp_pkg::BUF_LIMIT) begin
        st_ovf     = 1'b1;
        phase_next = ffrp_pkg::PH_HALT;
      end else begin
        wp_next = wp + 16'd1;
        if (!ffrp_pkg::is_ws(b)) mk_next = wp + 16'd1;
      end
    end
    if (st_trunc) phase_next = ffrp_pkg::PH_HALT;
    if (st_done || st_end) begin
      snl_next   = done_nl;
      ssl_next   = done_sl;
      wp_next    = '0;
      mk_next    = '0;
      fs_next    = '0;
      phase_next = ffrp_pkg::PH_WAIT;
    end
    // header byte: in the wait phase, or after a FASTA record closed by it
    if (!eos && !ffrp_pkg::is_ws(b) &&
        (phase == ffrp_pkg::PH_WAIT || (phase == ffrp_pkg::PH_FA_LSTART && st_done))) begin
      wp_next  = '0;
      mk_next  = '0;
      fs_next  = '0;
      snl_next = '0;
      ssl_next = '0;
      if (b == ffrp_pkg::CH_GT) begin
        fq_next    = 1'b0;
        phase_next = ffrp_pkg::PH_NAME_FIRST;
      end else if (b == ffrp_pkg::CH_AT) begin
        fq_next    = 1'b1;
        phase_next = ffrp_pkg::PH_NAME_FIRST;
      end else begin
        st_bad     = 1'b1;
        phase_next = ffrp_pkg::PH_HALT;
      end
    end
  end

  // results of the current byte
  always_comb begin
    res[0] = '0;
    res[1] = '0;
    cnt    = 2'd0;
    if (st_store) begin
      res[0].kind = st_ovf ? ffrp_pkg::K_OVERFLOW : ffrp_pkg::K_WRITE;
      if (!st_ovf) begin
        res[0].field    = st_fld;
        res[0].wr_addr  = wp;
        res[0].wr_byte  = b;
        res[0].is_fastq = fq;
      end
      cnt = 2'd1;
    end
    if (st_trunc) begin
      res[0].kind = ffrp_pkg::K_TRUNCATED;
      cnt         = 2'd1;
    end
    if (st_done) begin
      res[0].kind     = ffrp_pkg::K_DONE;
      res[0].is_fastq = fq;
      res[0].name_len = done_nl;
      res[0].seq_len  = done_sl;
      res[0].qual_len = done_ql;
      cnt             = 2'd1;
    end
    if (st_end) begin
      res[cnt[0]].kind = ffrp_pkg::K_STREAM_END;
      cnt              = cnt + 2'd1;
    end
    if (st_bad) begin
      res[cnt[0]].kind = ffrp_pkg::K_BAD_HEADER;
      cnt              = cnt + 2'd1;
    end
  end

  assign push.valid   = in_acc && (cnt != 2'd0);
  assign push.grp.r0  = res[0];
  assign push.grp.r1  = res[1];
  assign push.grp.two = cnt[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ffrp_pkg::PH_WAIT;
      wp    <= '0;
      mk    <= '0;
      fs    <= '0;
      snl   <= '0;
      ssl   <= '0;
      fq    <= 1'b0;
    end else if (in_acc) begin
      phase <= phase_next;
      wp    <= wp_next;
      mk    <= mk_next;
      fs    <= fs_next;
      snl   <= snl_next;
      ssl   <= ssl_next;
      fq    <= fq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_name     <= 1'b0;
      drop_sequence <= 1'b0;
      drop_quality  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ffrp_pkg::REG_DROP_NAME:     drop_name     <= cfg_data;
        ffrp_pkg::REG_DROP_SEQUENCE: drop_sequence <= cfg_data;
        ffrp_pkg::REG_DROP_QUALITY:  drop_quality  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ffrp_queue.sv
// Result queue: holds the result groups of accepted bytes and hands them out
// one result per transaction. Depends on ffrp_pkg and ffrp_out_if.
module ffrp_queue (
  input  logic            clk,
  input  logic            rst,
  input  ffrp_pkg::push_t push,
  output logic            full,
  ffrp_out_if.source      out_ch
);

  ffrp_pkg::group_t mem [ffrp_pkg::Q_DEPTH];
  logic [ffrp_pkg::Q_PTR_W-1:0] wptr, rptr;
  logic [ffrp_pkg::Q_PTR_W:0]   count;
  logic                         sub;    // which result of the head group is shown

  ffrp_pkg::group_t head;
  ffrp_pkg::res_t   cur;
  logic             is_last, out_acc, pop;

  assign head    = mem[rptr];
  assign cur     = sub ? head.r1 : head.r0;
  assign is_last = sub || !head.two;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign pop     = out_acc && is_last;
  assign full    = (count == (ffrp_pkg::Q_PTR_W + 1)'(ffrp_pkg::Q_DEPTH));

  assign out_ch.valid    = (count != '0);
  assign out_ch.kind     = cur.kind;
  assign out_ch.field    = cur.field;
  assign out_ch.wr_addr  = cur.wr_addr;
  assign out_ch.wr_byte  = cur.wr_byte;
  assign out_ch.is_fastq = cur.is_fastq;
  assign out_ch.name_len = cur.name_len;
  assign out_ch.seq_len  = cur.seq_len;
  assign out_ch.qual_len = cur.qual_len;
  assign out_ch.last     = is_last;

  always_ff @(posedge clk) begin
    if (push.valid) mem[wptr] <= push.grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      sub   <= 1'b0;
    end else begin
      if (push.valid) wptr <= wptr + 1'b1;
      if (out_acc) begin
        if (is_last) begin
          rptr <= rptr + 1'b1;
          sub  <= 1'b0;
        end else begin
          sub  <= 1'b1;
        end
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: test/ffrp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the record parser: watches the config port and both channels,
// predicts each result from the accepted bytes and compares it field by field.
// Depends on ffrp_pkg and the channel interfaces in ffrp_if.
module ffrp_checker import ffrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  ffrp_in_if                   in_ch,
  ffrp_out_if                  out_ch,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  field;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        fq;
    logic [15:0] nl;
    logic [15:0] sl;
    logic [15:0] ql;
    logic        last;
  } parse_res_t;

  phase_t      ph;
  logic [15:0] wptr, mark, fstart, name_keep, seq_keep;
  logic        fq_mode;
  logic        drop_nm, drop_sq, drop_ql;
  parse_res_t  step_q[$];
  parse_res_t  due[$];
  parse_res_t  head;

  function automatic logic blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  task automatic emit(input kind_t k, input logic [1:0] f = '0, input logic [15:0] a = '0,
                      input logic [7:0] d = '0, input logic q = 1'b0,
                      input logic [15:0] nl = '0, input logic [15:0] sl = '0,
                      input logic [15:0] ql = '0);
    parse_res_t r;
    r.kind  = k;
    r.field = f;
    r.addr  = a;
    r.data  = d;
    r.fq    = q;
    r.nl    = nl;
    r.sl    = sl;
    r.ql    = ql;
    r.last  = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic put_char(input logic [1:0] f, input logic [7:0] b);
    if (wptr >= BUF_LIMIT) begin
      emit(K_OVERFLOW);
      ph = PH_HALT;
    end else begin
      emit(K_WRITE, f, wptr, b, fq_mode);
      wptr++;
      if (!blank(b)) mark = wptr;
    end
  endtask

  task automatic clear_ptrs();
    wptr   = '0;
    mark   = '0;
    fstart = '0;
  endtask

  task automatic close_record(input logic [15:0] ql);
    emit(.k(K_DONE), .q(fq_mode), .nl(name_keep), .sl(seq_keep), .ql(ql));
    clear_ptrs();
    ph = PH_WAIT;
  endtask

  task automatic seek_header(input logic [7:0] b, input logic eos);
    if (eos) begin
      emit(K_STREAM_END);
      clear_ptrs();
      ph = PH_WAIT;
    end else if (!blank(b)) begin
      clear_ptrs();
      name_keep = '0;
      seq_keep  = '0;
      if (b == CH_GT) begin
        fq_mode = 1'b0;
        ph = PH_NAME_FIRST;
      end else if (b == CH_AT) begin
        fq_mode = 1'b1;
        ph = PH_NAME_FIRST;
      end else begin
        emit(K_BAD_HEADER);
        ph = PH_HALT;
      end
    end
  endtask

  // name trimmed to its last non-space byte, sequence follows it
  task automatic close_name();
    if (drop_nm) begin
      name_keep = '0;
      wptr = '0;
    end else begin
      name_keep = mark;
      wptr = mark;
    end
    fstart = wptr;
    mark = wptr;
  endtask

  task automatic cut_short();
    emit(K_TRUNCATED);
    ph = PH_HALT;
  endtask

  function automatic logic [15:0] qual_now();
    return drop_ql ? 16'd0 : 16'(mark - fstart);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    step_q.delete();
    case (ph)
      PH_WAIT: seek_header(b, eos);
      PH_NAME_FIRST, PH_NAME: begin
        if (eos) begin
          if (ph == PH_NAME_FIRST) begin
            seek_header(b, 1'b1);
          end else if (fq_mode) begin
            cut_short();
          end else begin
            close_name();
            seq_keep = '0;
            close_record('0);
            seek_header(b, 1'b1);
          end
        end else if (b == CH_LF) begin
          close_name();
          ph = fq_mode ? PH_FQ_SEQ : PH_FA_LSTART;
        end else begin
          ph = PH_NAME;
          if (!drop_nm) put_char(FLD_NAME, b);
        end
      end
      PH_FA_LSTART: begin
        if (eos) begin
          seq_keep = wptr - fstart;
          close_record('0);
          seek_header(b, 1'b1);
        end else if (blank(b)) begin
          // blank at line start: skipped
        end else if ((b >= CH_UPPER_A) && (b <= CH_LOWER_Z)) begin
          ph = PH_FA_LINE;
          put_char(FLD_SEQUENCE, b);
        end else begin
          // sequence over; this byte opens the next record
          seq_keep = wptr - fstart;
          close_record('0);
          seek_header(b, 1'b0);
        end
      end
      PH_FA_LINE: begin
        if (eos) begin
          wptr = mark;
          seq_keep = wptr - fstart;
          close_record('0);
          seek_header(b, 1'b1);
        end else if (b == CH_LF) begin
          wptr = mark;
          ph = PH_FA_LSTART;
        end else begin
          put_char(FLD_SEQUENCE, b);
        end
      end
      PH_FQ_SEQ: begin
        if (eos) begin
          cut_short();
        end else if (b == CH_LF) begin
          if (drop_sq) begin
            wptr = fstart;
            seq_keep = '0;
          end else begin
            wptr = mark;
            seq_keep = wptr - fstart;
          end
          fstart = wptr;
          mark = wptr;
          ph = PH_FQ_PLUS;
        end else if (!drop_sq) begin
          put_char(FLD_SEQUENCE, b);
        end
      end
      PH_FQ_PLUS: begin
        if (eos) cut_short();
        else if (b == CH_LF) ph = PH_FQ_QUAL_FIRST;
      end
      PH_FQ_QUAL_FIRST, PH_FQ_QUAL: begin
        if (eos) begin
          if (ph == PH_FQ_QUAL_FIRST) begin
            cut_short();
          end else begin
            close_record(qual_now());
            seek_header(b, 1'b1);
          end
        end else if (b == CH_LF) begin
          close_record(qual_now());
        end else begin
          ph = PH_FQ_QUAL;
          if (!drop_ql) put_char(FLD_QUALITY, b);
        end
      end
      default: begin
        // halted until reset
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) due.push_back(step_q[i]);
  endtask

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph        = PH_WAIT;
      clear_ptrs();
      name_keep = '0;
      seq_keep  = '0;
      fq_mode   = 1'b0;
      drop_nm   = 1'b0;
      drop_sq   = 1'b0;
      drop_ql   = 1'b0;
      due.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DROP_NAME:     drop_nm = cfg_data;
          REG_DROP_SEQUENCE: drop_sq = cfg_data;
          REG_DROP_QUALITY:  drop_ql = cfg_data;
          default: begin
          end
        endcase
      end
      // predict first so a same-edge result still finds its expectation
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.in_byte, in_ch.end_of_stream);
      if (out_ch.valid && out_ch.ready) begin
        if (due.size() == 0) begin
          $error("result with nothing expected: kind %0d", out_ch.kind);
          mismatches++;
        end else begin
          head = due.pop_front();
          compare_field("kind", head.kind, out_ch.kind);
          compare_field("field", head.field, out_ch.field);
          compare_field("wr_addr", head.addr, out_ch.wr_addr);
          compare_field("wr_byte", head.data, out_ch.wr_byte);
          compare_field("is_fastq", head.fq, out_ch.is_fastq);
          compare_field("name_len", head.nl, out_ch.name_len);
          compare_field("seq_len", head.sl, out_ch.seq_len);
          compare_field("qual_len", head.ql, out_ch.qual_len);
          compare_field("last", head.last, out_ch.last);
        end
      end
    end
    outstanding = due.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Top of the record parser testbench: clock, reset, byte streams, config writes
// and result back-pressure; checking is left to ffrp_checker.
// Depends on ffrp_pkg, ffrp_if, ffrp_checker and the parser RTL.
module tb;
  import ffrp_pkg::*;

  localparam int         LIMIT        = 1_000_000;
  localparam int         RAND_ITEMS   = 500;
  localparam int         FILL_LETTERS = 65600;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;

  typedef enum {END_BAD_HEADER, END_TRUNCATED, END_OVERFLOW, END_BAD_LINE} ending_t;

  // {end_of_stream, byte}: blanks before a header, end after a header, FASTA
  // ending in its name, FASTQ ending in quality, FASTA line start opening a record
  localparam logic [8:0] OPENING [24] = '{
    {1'b0, CH_SPACE}, {1'b0, CH_TAB}, {1'b0, CH_GT}, {1'b1, 8'h00},
    {1'b0, CH_GT}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_SPACE}, {1'b1, 8'hFF},
    {1'b0, CH_AT}, {1'b0, CH_LOWER_N}, {1'b0, CH_LF}, {1'b0, CH_UPPER_A}, {1'b0, CH_LF},
    {1'b0, CH_PLUS}, {1'b0, CH_LF}, {1'b0, CH_BANG}, {1'b1, 8'h00},
    {1'b0, CH_GT}, {1'b0, CH_LF}, {1'b0, CH_LOWER_Z}, {1'b0, CH_LF}, {1'b0, CH_AT},
    {1'b1, 8'h00}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   taken = 0;
  int                   hold_asks = 0;
  int                   holds_done = 0;
  bit                   calm = 1'b0;

  ffrp_in_if  in_ch ();
  ffrp_out_if out_ch ();

  fasta_fastq_record_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ffrp_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (errors),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] letter();
    return 8'($urandom_range(CH_UPPER_A, CH_LOWER_Z));
  endfunction

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] content();
    return ($urandom_range(0, 3) == 0) ? any_byte() : letter();
  endfunction

  function automatic logic [7:0] blank_char(input bit with_lf);
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 5);
    b = (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    if (!with_lf && (b == CH_LF)) b = CH_SPACE;
    return b;
  endfunction

  // neither blank, letter nor header byte
  function automatic logic [7:0] odd_byte();
    return $urandom_range(0, 1) ? 8'($urandom_range(CH_LOWER_Z + 1, 255))
                                : 8'($urandom_range(8'h30, 8'h39));
  endfunction

  // one input transaction; returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= eos ? 8'($urandom_range(0, 255)) : b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    taken++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  task automatic reconfigure(input int k);
    logic [2:0] bits;
    settle();
    bits = (k == 0) ? 3'b111 : (k == 1) ? 3'b000 : 3'($urandom);
    write_reg(REG_DROP_NAME, bits[0]);
    write_reg(REG_DROP_SEQUENCE, bits[1]);
    write_reg(REG_DROP_QUALITY, bits[2]);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_fasta(input bit cut);
    int lines;
    push_byte(CH_GT, 1'b0);
    repeat ($urandom_range(0, 10)) push_byte(content(), 1'b0);
    repeat ($urandom_range(0, 2)) push_byte(blank_char(1'b0), 1'b0);
    if (cut && $urandom_range(0, 1)) return;
    push_byte(CH_LF, 1'b0);
    lines = $urandom_range(0, 3);
    for (int i = 0; i < lines; i++) begin
      if ($urandom_range(0, 3) == 0) push_byte(blank_char(1'b1), 1'b0);
      push_byte(letter(), 1'b0);
      repeat ($urandom_range(0, 12)) push_byte(content(), 1'b0);
      repeat ($urandom_range(0, 1)) push_byte(blank_char(1'b0), 1'b0);
      if (!(cut && (i == lines - 1) && $urandom_range(0, 1))) push_byte(CH_LF, 1'b0);
    end
  endtask

  task automatic send_fastq(input bit cut);
    int q;
    push_byte(CH_AT, 1'b0);
    repeat ($urandom_range(0, 10)) push_byte(content(), 1'b0);
    repeat ($urandom_range(0, 2)) push_byte(blank_char(1'b0), 1'b0);
    push_byte(CH_LF, 1'b0);
    repeat ($urandom_range(0, 12)) push_byte(content(), 1'b0);
    repeat ($urandom_range(0, 1)) push_byte(blank_char(1'b0), 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_PLUS, 1'b0);
    repeat ($urandom_range(0, 3)) push_byte(content(), 1'b0);
    push_byte(CH_LF, 1'b0);
    q = $urandom_range(0, 12);
    repeat (q) push_byte(any_byte(), 1'b0);
    // a quality line may end at stream end only when it holds a byte
    if (!(cut && (q > 0) && $urandom_range(0, 1))) push_byte(CH_LF, 1'b0);
  endtask

  task automatic send_stream(input int min_n);
    int n;
    bit cut;
    n = $urandom_range(min_n, 4);
    if ((n == 0) && $urandom_range(0, 1))
      push_byte($urandom_range(0, 1) ? CH_GT : CH_AT, 1'b0);
    for (int r = 0; r < n; r++) begin
      cut = (r == n - 1) && ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(0, 2)) push_byte(blank_char(1'b1), 1'b0);
      if ($urandom_range(0, 1)) send_fasta(cut);
      else send_fastq(cut);
    end
    push_byte(8'h00, 1'b1);
  endtask

  // every ending halts the parser, so only one of them fits in a run
  task automatic finale();
    ending_t pick;
    int      sub;
    int      filled;
    int      len;
    pick = ending_t'($urandom_range(0, 3));
    case (pick)
      END_BAD_HEADER: begin
        push_byte(blank_char(1'b1), 1'b0);
        push_byte(odd_byte(), 1'b0);
      end
      END_TRUNCATED: begin
        sub = $urandom_range(0, 3);
        push_byte(CH_AT, 1'b0);
        push_byte(letter(), 1'b0);
        if (sub > 0) begin
          push_byte(CH_LF, 1'b0);
          push_byte(letter(), 1'b0);
        end
        if (sub > 1) begin
          push_byte(CH_LF, 1'b0);
          push_byte(CH_PLUS, 1'b0);
        end
        if (sub > 2) push_byte(CH_LF, 1'b0);
        push_byte(8'h00, 1'b1);
      end
      END_OVERFLOW: begin
        calm = 1'b1;
        push_byte(CH_GT, 1'b0);
        push_byte(CH_LF, 1'b0);
        filled = 0;
        while (filled < FILL_LETTERS) begin
          len = $urandom_range(1, 200);
          repeat (len) push_byte(letter(), 1'b0);
          push_byte(CH_LF, 1'b0);
          filled += len;
        end
      end
      default: begin
        push_byte(CH_GT, 1'b0);
        push_byte(letter(), 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(letter(), 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(odd_byte(), 1'b0);
      end
    endcase
    // halted: nothing more may come out
    repeat (20) push_byte(any_byte(), $urandom_range(0, 3) == 0);
  endtask

  // result side: random stall per transaction, one long hold on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int k;
    int w;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = REG_DROP_NAME;
    cfg_data            = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_stream = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (OPENING[i]) push_byte(OPENING[i][7:0], OPENING[i][8]);

    k = 0;
    while (taken < $size(OPENING) + RAND_ITEMS) begin
      if (k % 3 == 0) reconfigure(k / 3);
      calm = ($urandom_range(0, 4) == 0);
      if (k == 1) begin
        // long hold on results while bytes keep coming
        calm = 1'b0;
        hold_asks++;
        send_stream(4);
      end else begin
        send_stream(0);
      end
      k++;
    end

    settle();
    finale();

    in_ch.valid <= 1'b0;
    for (w = 0; (w < 5000) && (pending != 0); w++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if ((errors == 0) && (pending == 0)) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
